@@ rtl/lrukv_pkg.sv @@
// lrukv_pkg: shared constants, types and opcodes for the lru key/value cache
// no dependencies
`timescale 1ns / 1ps
package lrukv_pkg;
   localparam int MAX_ENTRIES = 16;
   localparam int KEY_BITS    = 32;
   localparam int VALUE_BITS  = 32;
   localparam int IDX_BITS    = 4;
   localparam int CNT_BITS    = 5;

   typedef logic [1:0]            opcode_type;
   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;

   localparam opcode_type OP_GET   = 2'd0;
   localparam opcode_type OP_PUT   = 2'd1;
   localparam opcode_type OP_DEL   = 2'd2;
   localparam opcode_type OP_CLEAR = 2'd3;

   // datapath commands
   typedef struct packed {
      logic    load;       // latch request
      logic    scan_clr;   // clear scan result flags
      logic    scan;       // examine entry at scan index
      logic    clear_all;  // empty store
      logic    touch;      // make found slot most recent (plus value read on get, value write on put)
      logic    insert;     // write request into free slot as most recent
      logic    drop_found; // drop found slot
      logic    drop_lru;   // drop least recent slot, report it
      logic    rsp_load;   // capture result
      idx_type scan_idx;
   } cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       found;
      logic       free_found;
      logic       lru_found;
      logic       over_cap;
      logic       full;
   } status_type;
endpackage

@@ rtl/lrukv_stream_if.sv @@
// lrukv_stream_if: valid/ready channel carrying a packed payload
// depends on nothing
`timescale 1ns / 1ps
interface lrukv_stream_if #(parameter int WIDTH = 1);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/lru_key_value_cache.sv @@
// lru_key_value_cache: top level of the lru key/value cache
// depends on lrukv_pkg, lrukv_stream_if, lrukv_controller, lrukv_datapath
`timescale 1ns / 1ps
// usage
//   req channel: transfer of {opcode, key, value}; opcode get, put, delete, clear
//   rsp channel: one transfer per request with {hit, read_value, evicted,
//     evicted_key, occupancy}
//   csr port: csr_write_enable / csr_write_data load the capacity register
//     (0 acts as 1, above 16 acts as 16); the user must write it only while
//     the block is idle, as the block itself does not enforce this
//   sequencing: every request starts with a key scan over 16 entries; a put
//     then either evicts from a full store and scans again for a free slot,
//     or runs an lru scan for the capacity check; one entry is scanned per cycle
//   throughput: one request at a time; the next request is taken once the
//     result is registered, even if the receiver has not yet taken it
//   reset: all entries invalid, occupancy zero, capacity 16
//   stall: a result held by the receiver waits in the output register;
//     a following result waits in the sequencer until that register frees
module lru_key_value_cache (
   input  logic                clock,
   input  logic                reset,
   lrukv_stream_if.sink        req,
   lrukv_stream_if.source      rsp,
   input  logic                csr_write_enable,
   input  lrukv_pkg::cnt_type  csr_write_data
);
   import lrukv_pkg::*;

   cmd_type    cmd;
   status_type status;
   cnt_type    capacity_ff;

   opcode_type req_opcode;
   key_type    req_key;
   value_type  req_value;

   logic      rsp_hit, rsp_evicted;
   value_type rsp_read_value;
   key_type   rsp_evicted_key;
   cnt_type   rsp_occupancy;

   // request payload packed as {opcode, key, value}
   assign req_opcode = req.data[KEY_BITS+VALUE_BITS+1 -: 2];
   assign req_key    = req.data[KEY_BITS+VALUE_BITS-1 -: KEY_BITS];
   assign req_value  = req.data[VALUE_BITS-1:0];

   // result payload packed as {hit, read_value, evicted, evicted_key, occupancy}
   assign rsp.data = {rsp_hit, rsp_read_value, rsp_evicted, rsp_evicted_key,
                      rsp_occupancy};

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) capacity_ff <= CNT_BITS'(MAX_ENTRIES);
      else if (csr_write_enable) capacity_ff <= csr_write_data;
   end

   lrukv_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lrukv_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_opcode      (req_opcode),
      .req_key         (req_key),
      .req_value       (req_value),
      .capacity        (capacity_ff),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .rsp_occupancy   (rsp_occupancy)
   );
endmodule

@@ rtl/lrukv_datapath.sv @@
// lrukv_datapath: entry registers, scan unit and recency rank update
// depends on lrukv_pkg
`timescale 1ns / 1ps
module lrukv_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  lrukv_pkg::cmd_type     cmd,
   output lrukv_pkg::status_type  status,
   input  lrukv_pkg::opcode_type  req_opcode,
   input  lrukv_pkg::key_type     req_key,
   input  lrukv_pkg::value_type   req_value,
   input  lrukv_pkg::cnt_type     capacity,
   output logic                   rsp_hit,
   output lrukv_pkg::value_type   rsp_read_value,
   output logic                   rsp_evicted,
   output lrukv_pkg::key_type     rsp_evicted_key,
   output lrukv_pkg::cnt_type     rsp_occupancy
);
   import lrukv_pkg::*;

   logic      valid_ff [MAX_ENTRIES];
   logic      valid_in [MAX_ENTRIES];
   key_type   key_ff   [MAX_ENTRIES];
   value_type val_ff   [MAX_ENTRIES];
   idx_type   rank_ff  [MAX_ENTRIES];
   idx_type   rank_in  [MAX_ENTRIES];
   cnt_type   count_ff, count_in;

   opcode_type op_ff;
   key_type    k_ff;
   value_type  v_ff;
   logic       found_ff, free_ff, lru_ok_ff;
   idx_type    found_idx_ff, free_idx_ff, lru_idx_ff;
   logic       hit_ff, ev_ff;
   value_type  rd_ff;
   key_type    evk_ff;

   cnt_type eff_cap;
   idx_type sel;
   idx_type sel_rank;
   logic    do_drop;
   logic    sel_hit, sel_free, sel_lru;

   always_comb begin
      if (capacity == '0) eff_cap = CNT_BITS'(1);
      else if (capacity > CNT_BITS'(MAX_ENTRIES)) eff_cap = CNT_BITS'(MAX_ENTRIES);
      else eff_cap = capacity;
   end

   assign sel_hit  = valid_ff[cmd.scan_idx] && key_ff[cmd.scan_idx] == k_ff;
   assign sel_free = !valid_ff[cmd.scan_idx];
   assign sel_lru  = valid_ff[cmd.scan_idx] &&
                     ({1'b0, rank_ff[cmd.scan_idx]} + CNT_BITS'(1)) == count_ff;

   assign do_drop = cmd.drop_found || cmd.drop_lru;
   assign sel     = cmd.drop_lru ? lru_idx_ff : found_idx_ff;
   assign sel_rank = rank_ff[sel];

   // rank and valid update, all entries in parallel
   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         rank_in[i]  = rank_ff[i];
         if (cmd.clear_all) begin
            valid_in[i] = 1'b0;
            rank_in[i]  = '0;
         end else if (cmd.touch) begin
            if (idx_type'(i) == found_idx_ff) rank_in[i] = '0;
            else if (valid_ff[i] && rank_ff[i] < sel_rank) rank_in[i] = rank_ff[i] + 1'b1;
         end else if (cmd.insert) begin
            if (idx_type'(i) == free_idx_ff) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
            end else if (valid_ff[i]) rank_in[i] = rank_ff[i] + 1'b1;
         end else if (do_drop) begin
            if (idx_type'(i) == sel) valid_in[i] = 1'b0;
            else if (valid_ff[i] && rank_ff[i] > sel_rank) rank_in[i] = rank_ff[i] - 1'b1;
         end
      end
      if (cmd.clear_all) count_in = '0;
      else if (cmd.insert) count_in = count_ff + 1'b1;
      else if (do_drop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            rank_ff[i]  <= '0;
         end
         count_ff <= '0;
      end else begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            valid_ff[i] <= valid_in[i];
            rank_ff[i]  <= rank_in[i];
         end
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_opcode;
         k_ff  <= req_key;
         v_ff  <= req_value;
         hit_ff <= 1'b0;
         ev_ff  <= 1'b0;
         rd_ff  <= '0;
         evk_ff <= '0;
      end
      if (cmd.scan_clr) begin
         found_ff  <= 1'b0;
         free_ff   <= 1'b0;
         lru_ok_ff <= 1'b0;
      end else if (cmd.scan) begin
         if (sel_hit && !found_ff) begin
            found_ff <= 1'b1;
            found_idx_ff <= cmd.scan_idx;
         end
         if (sel_free && !free_ff) begin
            free_ff <= 1'b1;
            free_idx_ff <= cmd.scan_idx;
         end
         if (sel_lru && !lru_ok_ff) begin
            lru_ok_ff <= 1'b1;
            lru_idx_ff <= cmd.scan_idx;
         end
      end
      if (cmd.touch) begin
         hit_ff <= 1'b1;
         if (op_ff == OP_GET) rd_ff <= val_ff[found_idx_ff];
         if (op_ff == OP_PUT) val_ff[found_idx_ff] <= v_ff;
      end
      if (cmd.insert) begin
         key_ff[free_idx_ff] <= k_ff;
         val_ff[free_idx_ff] <= v_ff;
      end
      if (cmd.drop_found) hit_ff <= 1'b1;
      if (cmd.drop_lru) begin
         ev_ff  <= 1'b1;
         evk_ff <= key_ff[lru_idx_ff];
      end
      if (cmd.rsp_load) begin
         rsp_hit         <= hit_ff;
         rsp_read_value  <= rd_ff;
         rsp_evicted     <= ev_ff;
         rsp_evicted_key <= evk_ff;
         rsp_occupancy   <= count_ff;
      end
   end

   assign status.opcode     = op_ff;
   assign status.found      = found_ff;
   assign status.free_found = free_ff;
   assign status.lru_found  = lru_ok_ff;
   assign status.over_cap   = count_ff > eff_cap;
   assign status.full       = count_ff >= CNT_BITS'(MAX_ENTRIES);
endmodule

@@ rtl/lrukv_controller.sv @@
// lrukv_controller: sequencer for decode, entry scan, update and result
// depends on lrukv_pkg
`timescale 1ns / 1ps
module lrukv_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  lrukv_pkg::status_type status,
   output lrukv_pkg::cmd_type    cmd
);
   import lrukv_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_ACT   = 3'd2;
   localparam logic [2:0] S_RESCN = 3'd3;
   localparam logic [2:0] S_INS   = 3'd4;
   localparam logic [2:0] S_CAP   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;
   idx_type    idx_ff, idx_in;
   logic       pend_ff, pend_in;
   logic       ev_done_ff, ev_done_in;
   logic       rsp_free;

   assign rsp_free  = !pend_ff || rsp_ready;
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = pend_ff;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      pend_in    = pend_ff && !rsp_ready;
      ev_done_in = ev_done_ff;
      cmd        = '0;
      cmd.scan_idx = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load     = 1'b1;
               cmd.scan_clr = 1'b1;
               idx_in       = '0;
               ev_done_in   = 1'b0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN, S_RESCN: begin
            cmd.scan = 1'b1;
            idx_in   = idx_ff + 1'b1;
            if (idx_ff == idx_type'(MAX_ENTRIES - 1)) begin
               state_in = (state_ff == S_SCAN) ? S_ACT : S_INS;
            end
         end
         S_ACT: begin
            unique case (status.opcode)
               OP_GET: begin
                  cmd.touch = status.found;
                  state_in  = S_DONE;
               end
               OP_PUT: begin
                  if (status.found) begin
                     // ranks change, so the lru search starts over
                     cmd.touch    = 1'b1;
                     cmd.scan_clr = 1'b1;
                     idx_in       = '0;
                     state_in     = S_CAP;
                  end else if (status.full && status.lru_found) begin
                     cmd.drop_lru = 1'b1;
                     ev_done_in   = 1'b1;
                     cmd.scan_clr = 1'b1;
                     idx_in       = '0;
                     state_in     = S_RESCN;
                  end else begin
                     state_in = S_INS;
                  end
               end
               OP_DEL: begin
                  cmd.drop_found = status.found;
                  state_in       = S_DONE;
               end
               default: begin
                  cmd.clear_all = 1'b1;
                  state_in      = S_DONE;
               end
            endcase
         end
         S_INS: begin
            cmd.insert   = status.free_found;
            cmd.scan_clr = 1'b1;
            idx_in       = '0;
            state_in     = S_CAP;
         end
         S_CAP: begin
            // lru search over the updated ranks, eviction follows in S_DONE
            if (ev_done_ff || !status.over_cap) begin
               state_in = S_DONE;
            end else begin
               cmd.scan = 1'b1;
               idx_in   = idx_ff + 1'b1;
               if (idx_ff == idx_type'(MAX_ENTRIES - 1)) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!ev_done_ff && status.over_cap && status.opcode == OP_PUT
                && status.lru_found) begin
               cmd.drop_lru = 1'b1;
               ev_done_in   = 1'b1;
            end else if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               pend_in      = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         idx_ff     <= '0;
         pend_ff    <= 1'b0;
         ev_done_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         pend_ff    <= pend_in;
         ev_done_ff <= ev_done_in;
      end
   end
endmodule

@@ sim/lru_key_value_cache_test.sv @@
// lru_key_value_cache_test: self-checking testbench for the lru key/value cache
// depends on lrukv_pkg, lrukv_stream_if and the lru_key_value_cache rtl
`timescale 1ns / 1ps
module lru_key_value_cache_test;
   import lrukv_pkg::*;

   // request and result layouts, packed in the order the ports carry them
   typedef struct packed {
      opcode_type opcode;
      key_type    key;
      value_type  value;
   } request_type;

   typedef struct packed {
      logic      hit;
      value_type read_value;
      logic      evicted;
      key_type   evicted_key;
      cnt_type   occupancy;
   } outcome_type;

   localparam int HOLD_CYCLES    = 250;  // long receiver hold-off
   localparam int DRAIN_CYCLES   = 60;   // longest put plus margin
   localparam int WATCHDOG_LIMIT = 3000; // cycles with no transfer at all

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic    csr_write_enable = 1'b0;
   cnt_type csr_write_data   = '0;

   lrukv_stream_if #(.WIDTH($bits(request_type))) req_if ();
   lrukv_stream_if #(.WIDTH($bits(outcome_type))) rsp_if ();

   lru_key_value_cache DUT (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   // shadow copy of the store, kept in step with every request transfer
   logic      shadow_valid [MAX_ENTRIES];
   key_type   shadow_key   [MAX_ENTRIES];
   value_type shadow_value [MAX_ENTRIES];
   int        shadow_rank  [MAX_ENTRIES];
   int        shadow_count;
   int        shadow_capacity;

   outcome_type pending_outcomes[$];
   key_type     key_pool[24];
   int          mismatch_count = 0;
   bit          idle_enabled   = 1'b1;
   bit          hold_request   = 1'b0;
   bit          timed_out      = 1'b0;

   // ---------------------------------------------------------------- predictor

   function automatic int shadow_find(key_type k);
      for (int i = 0; i < MAX_ENTRIES; i++)
         if (shadow_valid[i] && shadow_key[i] == k) return i;
      return -1;
   endfunction

   function automatic int shadow_oldest();
      for (int i = 0; i < MAX_ENTRIES; i++)
         if (shadow_valid[i] && shadow_rank[i] + 1 == shadow_count) return i;
      return -1;
   endfunction

   // move slot to the front, the entries ahead of it slide back by one
   function automatic void shadow_touch(int s);
      int r;
      r = shadow_rank[s];
      for (int i = 0; i < MAX_ENTRIES; i++)
         if (shadow_valid[i] && i != s && shadow_rank[i] < r) shadow_rank[i]++;
      shadow_rank[s] = 0;
   endfunction

   function automatic void shadow_drop(int s);
      int r;
      r = shadow_rank[s];
      shadow_valid[s] = 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++)
         if (shadow_valid[i] && shadow_rank[i] > r) shadow_rank[i]--;
      if (shadow_count > 0) shadow_count--;
   endfunction

   function automatic outcome_type cache_predict(request_type rq);
      outcome_type o;
      int s;
      int f;
      int cap;
      o = '0;
      cap = (shadow_capacity == 0) ? 1 :
            (shadow_capacity > MAX_ENTRIES) ? MAX_ENTRIES : shadow_capacity;
      case (rq.opcode)
         OP_GET: begin
            s = shadow_find(rq.key);
            if (s >= 0) begin
               o.hit = 1'b1;
               o.read_value = shadow_value[s];
               shadow_touch(s);
            end
         end
         OP_PUT: begin
            s = shadow_find(rq.key);
            if (s >= 0) begin
               o.hit = 1'b1;
               shadow_value[s] = rq.value;
               shadow_touch(s);
            end else begin
               // full store: the oldest entry makes room first
               if (shadow_count >= MAX_ENTRIES) begin
                  f = shadow_oldest();
                  if (f >= 0) begin
                     o.evicted = 1'b1;
                     o.evicted_key = shadow_key[f];
                     shadow_drop(f);
                  end
               end
               f = -1;
               for (int i = MAX_ENTRIES - 1; i >= 0; i--)
                  if (!shadow_valid[i]) f = i;
               if (f >= 0) begin
                  for (int j = 0; j < MAX_ENTRIES; j++)
                     if (shadow_valid[j]) shadow_rank[j]++;
                  shadow_valid[f] = 1'b1;
                  shadow_key[f]   = rq.key;
                  shadow_value[f] = rq.value;
                  shadow_rank[f]  = 0;
                  shadow_count++;
               end
            end
            // at most one eviction per put, even when capacity dropped a lot
            if (!o.evicted && shadow_count > cap) begin
               f = shadow_oldest();
               if (f >= 0) begin
                  o.evicted = 1'b1;
                  o.evicted_key = shadow_key[f];
                  shadow_drop(f);
               end
            end
         end
         OP_DEL: begin
            s = shadow_find(rq.key);
            if (s >= 0) begin
               o.hit = 1'b1;
               shadow_drop(s);
            end
         end
         default: begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               shadow_valid[i] = 1'b0;
               shadow_rank[i]  = 0;
            end
            shadow_count = 0;
         end
      endcase
      o.occupancy = cnt_type'(shadow_count);
      return o;
   endfunction

   // ---------------------------------------------------------------- sender

   // offer one request until it transfers, then maybe leave a gap
   task automatic send_request(opcode_type op, key_type k, value_type v);
      request_type rq;
      rq = '{opcode: op, key: k, value: v};
      req_if.valid <= 1'b1;
      req_if.data  <= rq;
      do @(posedge clock); while (!req_if.ready);
      pending_outcomes = {pending_outcomes, cache_predict(rq)};
      if (idle_enabled && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // capacity is only written with the block idle and every result back
   task automatic set_capacity(cnt_type c);
      req_if.valid <= 1'b0;
      wait (pending_outcomes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= c;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_capacity = c;
   endtask

   function automatic key_type pick_key();
      if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 23)];
      return $urandom;
   endfunction

   function automatic opcode_type pick_opcode();
      int r;
      r = $urandom_range(0, 99);
      if (r < 42) return OP_PUT;
      if (r < 77) return OP_GET;
      if (r < 97) return OP_DEL;
      return OP_CLEAR;
   endfunction

   // ---------------------------------------------------------------- receiver

   // checks each result transfer, and drives ready with random stalls
   initial begin
      int stall_left;
      outcome_type got;
      outcome_type want;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (pending_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result %p", got);
            end else begin
               want = pending_outcomes.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("result mismatch: expected %p, actual %p", want, got);
               end
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // watchdog: too long without any transfer ends the run
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // corner keys and values, every opcode, misses, clear, full-store insert
   task automatic test_basic_operations();
      send_request(OP_GET,   32'h0000_0000, 32'h1234_5678);    // get miss on empty
      send_request(OP_PUT,   32'h0000_0000, 32'h0000_0000);
      send_request(OP_PUT,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_GET,   32'hFFFF_FFFF, 32'h0);
      send_request(OP_GET,   32'h0000_0000, 32'hFFFF_FFFF);
      send_request(OP_PUT,   32'h0000_0000, 32'hA5A5_5A5A);    // update in place
      send_request(OP_GET,   32'h0000_0000, 32'h0);
      send_request(OP_DEL,   32'h1111_1111, 32'h0);            // delete miss
      send_request(OP_DEL,   32'hFFFF_FFFF, 32'h0);
      send_request(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_GET,   32'h0000_0000, 32'h0);
      // seventeen new keys into sixteen slots
      for (int i = 0; i < 17; i++)
         send_request(OP_PUT, 32'h8000_0000 | i, ~i);
      send_request(OP_GET, 32'h8000_0001, 32'h0);
   endtask

   // capacity extremes: zero, one, above the slot count, lowered under occupancy
   task automatic test_capacity_limits();
      set_capacity(5'd0);
      for (int i = 0; i < 3; i++) send_request(OP_PUT, key_pool[i], $urandom);
      set_capacity(5'd31);
      for (int i = 0; i < 18; i++) send_request(OP_PUT, key_pool[i], $urandom);
      set_capacity(5'd4);
      for (int i = 18; i < 24; i++) send_request(OP_PUT, key_pool[i], $urandom);
      set_capacity(5'd1);
      send_request(OP_PUT, key_pool[0], $urandom);
      set_capacity(5'd17);
      send_request(OP_PUT, key_pool[1], $urandom);
      set_capacity(5'd16);
   endtask

   // receiver holds off while requests keep coming, then the sender waits
   task automatic test_backpressure();
      hold_request = 1'b1;
      for (int i = 0; i < 8; i++) send_request(pick_opcode(), pick_key(), $urandom);
      req_if.valid <= 1'b0;
      wait (pending_outcomes.size() == 0);
      for (int i = 0; i < 8; i++) send_request(OP_PUT, pick_key(), $urandom);
   endtask

   task automatic test_random_traffic();
      cnt_type caps[6] = '{5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd0};
      for (int p = 0; p < 5; p++) begin
         caps[5] = cnt_type'($urandom_range(0, 31));
         set_capacity(caps[$urandom_range(0, 5)]);
         if (p == 4) idle_enabled = 1'b0; // last phase runs at full rate
         for (int i = 0; i < 100; i++) send_request(pick_opcode(), pick_key(), $urandom);
      end
   endtask

   initial begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_key[i]   = '0;
         shadow_value[i] = '0;
         shadow_rank[i]  = 0;
      end
      shadow_count    = 0;
      shadow_capacity = MAX_ENTRIES;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 24; i++) key_pool[i] = $urandom;
      req_if.valid = 1'b0;
      req_if.data  = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_operations();
      test_capacity_limits();
      test_backpressure();
      test_random_traffic();

      req_if.valid <= 1'b0;
      wait (pending_outcomes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
